// ----- hw/rtl/ucm_pkg.sv -----
`timescale 1ns / 1ps

package ucm_pkg;

   localparam int UCM_MAX_LINE_LEN = 16;
   localparam int UCM_CMD_COUNT    = 3;
   localparam int UCM_CMD_MAX_LEN  = 8;

   localparam logic [7:0] BYTE_LF  = 8'h0A;
   localparam logic [7:0] BYTE_CR  = 8'h0D;
   localparam logic [7:0] BYTE_DEL = 8'h7F;

   typedef enum logic [1:0] {
      CODE_RESET    = 2'd0,
      CODE_SET_UART = 2'd1,
      CODE_HELP     = 2'd2,
      CODE_INVALID  = 2'd3
   } command_code_type;

   typedef enum logic [1:0] {
      CLS_CHAR     = 2'd0,
      CLS_DELETE   = 2'd1,
      CLS_LINE_END = 2'd2
   } item_class_type;

   typedef struct packed {
      item_class_type cls;
      logic [7:0]     data;
   } queue_item_type;

   typedef struct packed {
      logic           valid;
      queue_item_type item;
   } queue_head_type;

   // Command strings, padded with zero bytes past their length.
   localparam logic [7:0] UCM_CMD_TEXT [UCM_CMD_COUNT][UCM_CMD_MAX_LEN] = '{
      '{"R", "e", "s", "e", "t", 8'h00, 8'h00, 8'h00},
      '{"S", "e", "t", " ", "U", "A", "R", "T"},
      '{"H", "e", "l", "p", 8'h00, 8'h00, 8'h00, 8'h00}
   };

   localparam logic [3:0] UCM_CMD_LEN [UCM_CMD_COUNT] = '{4'd5, 4'd8, 4'd4};

endpackage

// ----- hw/rtl/ucm_front.sv -----
`timescale 1ns / 1ps

module ucm_front (
   input  logic [7:0]              rx_byte,
   output ucm_pkg::queue_item_type item
);
   import ucm_pkg::*;

   always_comb begin
      item.data = rx_byte;
      if (rx_byte == BYTE_LF || rx_byte == BYTE_CR) begin
         item.cls = CLS_LINE_END;
      end else if (rx_byte == BYTE_DEL) begin
         item.cls = CLS_DELETE;
      end else begin
         item.cls = CLS_CHAR;
      end
   end

endmodule

// ----- hw/rtl/ucm_queue.sv -----
`timescale 1ns / 1ps

module ucm_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  ucm_pkg::queue_item_type push_item,
   output logic                    full,
   input  logic                    pop,
   output ucm_pkg::queue_head_type head
);
   import ucm_pkg::*;

   localparam int DEPTH = 2;

   queue_item_type entry_ff [DEPTH];
   logic           wr_ptr_ff;
   logic           wr_ptr_in;
   logic           rd_ptr_ff;
   logic           rd_ptr_in;
   logic [1:0]     count_ff;
   logic [1:0]     count_in;

   assign full       = (count_ff == 2'(DEPTH));
   assign head.valid = (count_ff != 2'd0);
   assign head.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- hw/rtl/ucm_back.sv -----
`timescale 1ns / 1ps

module ucm_back #(
   parameter int MAX_LINE_LEN = ucm_pkg::UCM_MAX_LINE_LEN
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ucm_pkg::queue_head_type head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_command_code
);
   import ucm_pkg::*;

   localparam int COUNT_W = $clog2(MAX_LINE_LEN + 2);

   // Only the first entries can ever take part in a match, so only they are kept.
   logic [7:0]       store_ff [UCM_CMD_MAX_LEN];
   logic [COUNT_W-1:0] char_count_ff;
   logic [COUNT_W-1:0] char_count_in;
   logic [COUNT_W-1:0] base_count;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   command_code_type code_ff;
   command_code_type code_in;
   command_code_type match_code;
   logic [UCM_CMD_COUNT-1:0] cmd_hit;
   logic             is_line_end;
   logic             store_write;

   assign is_line_end = (head.item.cls == CLS_LINE_END);
   // A line end needs the output register; other transactions never wait.
   assign pop = head.valid && (!is_line_end || !rsp_valid_ff || !rsp_stall);

   // An overlong line restarts before the byte is handled.
   assign base_count = (char_count_ff > COUNT_W'(MAX_LINE_LEN)) ? '0 : char_count_ff;

   always_comb begin
      for (int k = 0; k < UCM_CMD_COUNT; k++) begin
         cmd_hit[k] = (char_count_ff == COUNT_W'(UCM_CMD_LEN[k]));
         for (int i = 0; i < UCM_CMD_MAX_LEN; i++) begin
            if (4'(i) < UCM_CMD_LEN[k] && store_ff[i] != UCM_CMD_TEXT[k][i]) begin
               cmd_hit[k] = 1'b0;
            end
         end
      end
      if (cmd_hit[0]) begin
         match_code = CODE_RESET;
      end else if (cmd_hit[1]) begin
         match_code = CODE_SET_UART;
      end else if (cmd_hit[2]) begin
         match_code = CODE_HELP;
      end else begin
         match_code = CODE_INVALID;
      end
   end

   always_comb begin
      char_count_in = char_count_ff;
      store_write   = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      code_in       = code_ff;
      if (pop) begin
         case (head.item.cls)
            CLS_LINE_END: begin
               char_count_in = '0;
               rsp_valid_in  = 1'b1;
               // A wrapped count is above every command length, so the raw
               // count gives the same compare as the wrapped one.
               code_in       = match_code;
            end
            CLS_DELETE: begin
               char_count_in = (base_count != '0) ? base_count - COUNT_W'(1) : '0;
            end
            CLS_CHAR: begin
               char_count_in = base_count + COUNT_W'(1);
               store_write   = 1'b1;
            end
            default: begin
               char_count_in = char_count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         char_count_ff <= char_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      for (int i = 0; i < UCM_CMD_MAX_LEN; i++) begin
         if (store_write && base_count == COUNT_W'(i)) begin
            store_ff[i] <= head.item.data;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_command_code = code_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      char_count_ff <= COUNT_W'(MAX_LINE_LEN + 1))
      else $error("character count above line limit plus one");

   a_line_end_clears: assert property (@(posedge clock) disable iff (reset)
      (pop && is_line_end) |=> (char_count_ff == '0 && rsp_valid_ff))
      else $error("line end did not clear count and load a result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !(pop && is_line_end))
      else $error("pending result overwritten");

endmodule

// ----- hw/rtl/uart_command_line_matcher_core.sv -----
`timescale 1ns / 1ps

// Serial command line matcher.
// The req_ channel carries one received byte per transaction on req_rx_byte.
// Line feed or carriage return ends a line, 0x7F deletes the last character,
// and every other byte is stored as a character. At each line end the line
// is compared with the commands "Reset", "Set UART" and "Help", and one
// transaction on the rsp_ channel carries rsp_command_code: 0 Reset,
// 1 Set UART, 2 Help, 3 invalid. Other bytes give no response.
// A line longer than MAX_LINE_LEN restarts from the next byte.
// One byte is accepted per cycle while req_stall is low. A byte enters a two-entry queue; the line
// logic takes one queued byte per cycle unless a line end waits for the held result, and a result
// is registered in the output register after its line end has passed through the queue.
// While rsp_stall holds a result, ordinary bytes keep flowing; a further
// line end waits in the queue, and req_stall rises once the queue is full.
// Synchronous reset empties the queue, drops any pending result and clears
// the character count; the block is ready in the first cycle after reset.
module uart_command_line_matcher_core #(
   parameter int MAX_LINE_LEN = ucm_pkg::UCM_MAX_LINE_LEN
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_command_code
);
   import ucm_pkg::*;

   queue_item_type front_item;
   queue_head_type head;
   logic           queue_full;
   logic           push;
   logic           pop;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   ucm_front u_front (
      .rx_byte (req_rx_byte),
      .item    (front_item)
   );

   ucm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (pop),
      .head      (head)
   );

   ucm_back #(
      .MAX_LINE_LEN (MAX_LINE_LEN)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_command_code (rsp_command_code)
   );

endmodule

// ----- test/command_line_checker.sv -----
`timescale 1ns / 1ps

module command_line_checker #(
   parameter int MAX_LINE_LEN = ucm_pkg::UCM_MAX_LINE_LEN
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [1:0] rsp_command_code,
   output int         error_count,
   output int         pending_count
);
   import ucm_pkg::*;

   string            command_names [UCM_CMD_COUNT] = '{"Reset", "Set UART", "Help"};
   command_code_type command_codes [UCM_CMD_COUNT] = '{CODE_RESET, CODE_SET_UART, CODE_HELP};

   logic [7:0]       line_bytes [MAX_LINE_LEN + 1];
   int               line_len;
   command_code_type expected_codes [$];
   command_code_type oldest_code;
   int               mismatch_total;

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatch_total++;
   endtask

   // A line matches a command only when both the length and every byte agree.
   function automatic command_code_type decode_line();
      bit same;
      for (int k = 0; k < UCM_CMD_COUNT; k++) begin
         same = (line_len == command_names[k].len());
         for (int i = 0; same && i < line_len; i++) begin
            if (line_bytes[i] != command_names[k][i]) same = 1'b0;
         end
         if (same) return command_codes[k];
      end
      return CODE_INVALID;
   endfunction

   task automatic absorb_byte(input logic [7:0] value);
      // A line that overran the store restarts before the next byte is handled.
      if (line_len > MAX_LINE_LEN) line_len = 0;
      case (value)
         BYTE_LF, BYTE_CR: begin
            expected_codes.push_back(decode_line());
            line_len = 0;
         end
         BYTE_DEL: begin
            if (line_len > 0) line_len--;
         end
         default: begin
            line_bytes[line_len] = value;
            line_len++;
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         line_len = 0;
         mismatch_total = 0;
         expected_codes.delete();
         pending_count <= 0;
         error_count <= 0;
      end else begin
         // Responses first, so a spurious one is never paired with a line end
         // accepted at the same edge.
         if (rsp_valid && !rsp_stall) begin
            if (expected_codes.size() == 0) begin
               report_mismatch($sformatf("code %0d with no line end waiting",
                                         rsp_command_code));
            end else begin
               oldest_code = expected_codes.pop_front();
               if (rsp_command_code !== oldest_code) begin
                  report_mismatch($sformatf("command_code %0d, expected %0d (%s)",
                                            rsp_command_code, oldest_code,
                                            oldest_code.name()));
               end
            end
         end
         if (req_valid && !req_stall) absorb_byte(req_rx_byte);
         pending_count <= expected_codes.size();
         error_count <= mismatch_total;
      end
   end

endmodule

// ----- test/uart_command_line_matcher_core_test.sv -----
`timescale 1ns / 1ps

module uart_command_line_matcher_core_test;
   import ucm_pkg::*;

   localparam int RANDOM_BYTES = 550;
   localparam int STALL_LIMIT  = 1000;
   localparam int LONG_HOLD    = 120;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [1:0] rsp_command_code;

   int         error_count;
   int         pending_count;
   int         sent_count;
   int         idle_cycles;
   bit         quiet_sender;
   logic [7:0] line_q [$];
   string      command_texts [UCM_CMD_COUNT] = '{"Reset", "Set UART", "Help"};

   uart_command_line_matcher_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_command_code (rsp_command_code)
   );

   command_line_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_command_code (rsp_command_code),
      .error_count      (error_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [7:0] ordinary_byte();
      logic [7:0] v;
      do v = 8'($urandom_range(0, 255));
      while (v == BYTE_LF || v == BYTE_CR || v == BYTE_DEL);
      return v;
   endfunction

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
   endtask

   task automatic send_byte(input logic [7:0] value);
      int gap;
      gap = quiet_sender ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   task automatic send_line();
      quiet_sender = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < line_q.size(); i++) send_byte(line_q[i]);
      line_q.delete();
   endtask

   // Receiver: a random hold-off before each transaction, and two long holds
   // that back line ends up into the input queue.
   initial begin : receiver
      int hold;
      int results;
      rsp_stall = 1'b0;
      results = 0;
      forever begin
         if (results == 15 || results == 60) hold = LONG_HOLD;
         else if ($urandom_range(0, 3) == 0) hold = 0;
         else hold = $urandom_range(0, 6);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         results++;
      end
   end

   initial begin : stimulus
      int         kind;
      int         pos;
      int         random_start;
      string      cmd;
      logic [7:0] term;
      bit         noise;

      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = 8'h00;
      sent_count = 0;
      quiet_sender = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      push_text("Reset");
      line_q.push_back(BYTE_CR);
      send_line();
      push_text("Set UART");
      line_q.push_back(BYTE_LF);
      send_line();
      // A typo removed by delete still matches.
      push_text("Hel");
      line_q.push_back(BYTE_DEL);
      push_text("lp");
      line_q.push_back(BYTE_LF);
      send_line();
      // Delete on an empty line, then the zero byte and the top byte as characters.
      line_q.push_back(BYTE_DEL);
      line_q.push_back(8'h00);
      line_q.push_back(8'hFF);
      line_q.push_back(BYTE_LF);
      send_line();

      random_start = sent_count;
      while (sent_count - random_start < RANDOM_BYTES) begin
         cmd = command_texts[$urandom_range(0, UCM_CMD_COUNT - 1)];
         term = $urandom_range(0, 1) ? BYTE_CR : BYTE_LF;
         noise = 1'b0;
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            push_text(cmd);
         end else if (kind < 50) begin
            // Near miss: one bit off, one character short or one too many.
            push_text(cmd);
            pos = $urandom_range(0, line_q.size() - 1);
            case ($urandom_range(0, 2))
               0: line_q[pos] = line_q[pos] ^ 8'(1 << $urandom_range(0, 7));
               1: line_q.delete(line_q.size() - 1);
               default: line_q.push_back(ordinary_byte());
            endcase
         end else if (kind < 62) begin
            repeat ($urandom_range(0, 2)) line_q.push_back(BYTE_DEL);
            push_text(cmd);
            pos = $urandom_range(0, line_q.size());
            line_q.insert(pos, BYTE_DEL);
            line_q.insert(pos, ordinary_byte());
         end else if (kind < 74) begin
            // Around and past the line length, optionally followed by a command.
            repeat ($urandom_range(15, 34)) line_q.push_back(ordinary_byte());
            if ($urandom_range(0, 1)) push_text(cmd);
         end else if (kind < 90) begin
            repeat ($urandom_range(0, 12)) line_q.push_back(ordinary_byte());
         end else begin
            noise = 1'b1;
            repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(0, 255)));
         end
         if (!noise) line_q.push_back(term);
         send_line();
      end
      req_valid <= 1'b0;

      // The checker counts the last transaction only after the edge that accepted it.
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/ucm_pkg.sv
hw/rtl/ucm_front.sv
hw/rtl/ucm_queue.sv
hw/rtl/ucm_back.sv
hw/rtl/uart_command_line_matcher_core.sv
test/command_line_checker.sv
test/uart_command_line_matcher_core_test.sv
